// ===== rtl/cito_pkg.sv =====
// Package for the cubic interpolating wavetable oscillator.
// Holds the shared widths, fixed-point constants, multiplier operand codes
// and the phase reload function. Depends on nothing.
package cito_pkg;

   localparam int TABLE_BITS  = 10;
   localparam int FRAC_BITS   = 16;
   localparam int SAMPLE_BITS = 16;

   localparam int PHASE_BITS = TABLE_BITS + FRAC_BITS;
   localparam int TABLE_SIZE = 1 << TABLE_BITS;

   localparam int AMP_FRAC = 15;
   localparam int INIT_BITS = 16;

   localparam int T_W = SAMPLE_BITS + 6;

   localparam int MA_W = T_W + 2;
   localparam int MB_W = (FRAC_BITS + 1 > T_W + 3) ? FRAC_BITS + 1 : T_W + 3;
   localparam int P_W  = MA_W + MB_W;

   localparam int DIV_SHIFT = T_W + 3;
   localparam logic [63:0] RECIP = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;

   localparam logic [1:0] MUL_FRAC  = 2'd0;
   localparam logic [1:0] MUL_AMP   = 2'd1;
   localparam logic [1:0] MUL_RECIP = 2'd2;

   typedef struct packed {
      logic       en;
      logic [1:0] sel;
   } mul_req_type;

   function automatic logic [PHASE_BITS-1:0] load_phase(input logic [INIT_BITS-1:0] val);
      logic [PHASE_BITS-1:0] p;
      int k;
      p = '0;
      for (int j = 0; j < PHASE_BITS; j++) begin
         k = j + INIT_BITS - PHASE_BITS;
         if (k >= 0) begin
            p[j] = val[k];
         end
      end
      return p - (PHASE_BITS'(1) << FRAC_BITS);
   endfunction

endpackage

// ===== rtl/cito_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the waveform table. Depends on nothing.
module cito_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cito_mul.sv =====
// Shared signed multiplier with operand selection and a registered product.
// Serves the Horner steps, the amplitude scaling and the divide by three.
// Depends on cito_pkg.
module cito_mul (
   input  logic                              clock,
   input  cito_pkg::mul_req_type             req,
   input  logic signed [cito_pkg::T_W-1:0]   t_val,
   input  logic [cito_pkg::FRAC_BITS-1:0]    frac,
   input  logic signed [15:0]                amp,
   input  logic [cito_pkg::T_W:0]            u_val,
   output logic signed [cito_pkg::P_W-1:0]   prod
);

   logic signed [cito_pkg::MA_W-1:0] opa;
   logic signed [cito_pkg::MB_W-1:0] opb;
   logic signed [cito_pkg::P_W-1:0]  prod_ff;

   always_comb begin
      unique case (req.sel)
         cito_pkg::MUL_FRAC: begin
            opa = cito_pkg::MA_W'(t_val);
            opb = signed'(cito_pkg::MB_W'(frac));
         end
         cito_pkg::MUL_AMP: begin
            opa = cito_pkg::MA_W'(t_val);
            opb = cito_pkg::MB_W'(amp);
         end
         cito_pkg::MUL_RECIP: begin
            opa = signed'(cito_pkg::MA_W'(u_val));
            opb = signed'(cito_pkg::MB_W'(cito_pkg::RECIP));
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= cito_pkg::P_W'(opa) * cito_pkg::P_W'(opb);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/cubic_interp_table_oscillator_unit.sv =====
// Top level of the cubic interpolating wavetable oscillator.
// Holds the sequencer, phase accumulator and working registers; uses
// cito_pkg, cito_ram and cito_mul.
//
// Usage:
// The req_ channel carries one item per handshake. An item with operation 0
// writes table_value into the waveform table at table_index and produces no
// result; the block stays ready for the next item. An item with operation 1
// produces one sample on the rsp_ channel. The block reads the four
// neighboring table entries one per cycle from the single table read port,
// then runs the cubic through the shared multiplier: three Horner steps, each
// a multiply and then an add, the amplitude scaling and a multiply by the
// reciprocal of three. The block returns to idle as the sample enters the
// output register, and only then takes a new item.
// req_stall is high while a sample is in work.
// The csr_ channel reloads the phase from initial_phase, one entry back; it
// is always ready. Reset clears the phase to zero minus one entry and drops
// rsp_valid; the table contents are undefined until written.
// A result waits in the output register while rsp_stall is high, and the
// next item is accepted meanwhile; a later sample holds in its last step
// until the output register is free.
module cubic_interp_table_oscillator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [9:0]         req_table_index,
   input  logic signed [15:0] req_table_value,
   input  logic signed [26:0] req_phase_increment,
   input  logic signed [15:0] req_amplitude,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_initial_phase
);

   localparam int T_W = cito_pkg::T_W;
   localparam int S_W = cito_pkg::SAMPLE_BITS;
   localparam int A_W = cito_pkg::TABLE_BITS;
   localparam int F_W = cito_pkg::FRAC_BITS;
   localparam int PH_W = cito_pkg::PHASE_BITS;
   localparam int P_W = cito_pkg::P_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_READ  = 4'd1;
   localparam logic [3:0] ST_COEF  = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_ADD   = 4'd4;
   localparam logic [3:0] ST_SCALE = 4'd5;
   localparam logic [3:0] ST_OFFS  = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_SAT   = 4'd8;

   localparam logic [2:0] RD_LAST = 3'd4;
   localparam logic [1:0] H_LAST  = 2'd2;

   localparam logic signed [P_W-1:0] ROUND_OFS = P_W'(3 * (1 << cito_pkg::AMP_FRAC));
   localparam logic signed [T_W+1:0] U_OFS = (T_W + 2)'(3) << (T_W - 1);
   localparam logic signed [T_W-1:0] SAMP_MAX = T_W'((1 << (S_W - 1)) - 1);
   localparam logic signed [T_W-1:0] SAMP_MIN = -T_W'(1 << (S_W - 1));

   logic [3:0]              state_ff, state_in;
   logic [2:0]              rd_cnt_ff, rd_cnt_in;
   logic [1:0]              h_cnt_ff, h_cnt_in;
   logic [PH_W-1:0]         phase_ff, phase_in;
   logic [A_W-1:0]          idx_ff, idx_in;
   logic [F_W-1:0]          frac_ff, frac_in;
   logic signed [15:0]      amp_ff, amp_in;
   logic signed [S_W-1:0]   tap_ff [4];
   logic signed [S_W-1:0]   tap_in [4];
   logic signed [T_W-1:0]   t_ff, t_in;
   logic signed [T_W-1:0]   coef_ff [3];
   logic signed [T_W-1:0]   coef_in [3];
   logic [T_W:0]            u_ff, u_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]      rsp_sample_ff, rsp_sample_in;

   logic                    req_accept;
   logic                    csr_accept;
   logic                    ram_we;
   logic [A_W-1:0]          ram_wr_addr;
   logic [S_W-1:0]          ram_wr_data;
   logic [A_W-1:0]          ram_rd_addr;
   logic [S_W-1:0]          ram_rd_data;
   cito_pkg::mul_req_type   mul_req;
   logic signed [P_W-1:0]   prod;

   logic signed [T_W-1:0]   ta, tb, tc, td, ta3, tb3, tc3;
   logic signed [T_W-1:0]   k3, k2, k1, k0;
   logic signed [P_W-1:0]   prod_sh;
   logic signed [P_W-1:0]   round_sum;
   logic signed [T_W-1:0]   q_val;
   logic signed [T_W+1:0]   u_sum;
   logic [T_W-1:0]          quot;
   logic signed [T_W-1:0]   r_val;
   logic signed [T_W-1:0]   r_sat;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   assign ram_we      = req_accept && !req_operation;
   assign ram_wr_addr = A_W'(req_table_index);
   assign ram_wr_data = S_W'(req_table_value);
   assign ram_rd_addr = idx_ff + A_W'(rd_cnt_ff[1:0]);

   cito_ram #(
      .WIDTH(S_W),
      .DEPTH(cito_pkg::TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cito_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .t_val (t_ff),
      .frac  (frac_ff),
      .amp   (amp_ff),
      .u_val (u_ff),
      .prod  (prod)
   );

   assign ta  = T_W'(tap_ff[0]);
   assign tb  = T_W'(tap_ff[1]);
   assign tc  = T_W'(tap_ff[2]);
   assign td  = T_W'(tap_ff[3]);
   assign ta3 = (ta <<< 1) + ta;
   assign tb3 = (tb <<< 1) + tb;
   assign tc3 = (tc <<< 1) + tc;
   assign k3  = td - ta + tb3 - tc3;
   assign k2  = ta3 + tc3 - (tb3 <<< 1);
   assign k1  = (tc3 <<< 1) - td - tb3 - (ta <<< 1);
   assign k0  = tb3 <<< 1;

   assign prod_sh   = prod >>> F_W;
   assign round_sum = prod + ROUND_OFS;
   assign q_val     = T_W'(round_sum >>> (cito_pkg::AMP_FRAC + 1));
   assign u_sum     = (T_W + 2)'(q_val) + U_OFS;

   // The quotient is offset by half the range, so flipping its top bit
   // removes the offset that kept the dividend positive.
   assign quot  = prod[cito_pkg::DIV_SHIFT +: T_W];
   assign r_val = signed'({~quot[T_W-1], quot[T_W-2:0]});

   always_comb begin
      priority if (r_val > SAMP_MAX) begin
         r_sat = SAMP_MAX;
      end else if (r_val < SAMP_MIN) begin
         r_sat = SAMP_MIN;
      end else begin
         r_sat = r_val;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      h_cnt_in      = h_cnt_ff;
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      frac_in       = frac_ff;
      amp_in        = amp_ff;
      tap_in        = tap_ff;
      t_in          = t_ff;
      coef_in       = coef_ff;
      u_in          = u_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      mul_req.en    = 1'b0;
      mul_req.sel   = cito_pkg::MUL_FRAC;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_operation) begin
               idx_in    = phase_ff[PH_W-1:F_W];
               frac_in   = phase_ff[F_W-1:0];
               amp_in    = req_amplitude;
               phase_in  = phase_ff + PH_W'(req_phase_increment);
               rd_cnt_in = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            if (rd_cnt_ff != '0) begin
               tap_in[0] = tap_ff[1];
               tap_in[1] = tap_ff[2];
               tap_in[2] = tap_ff[3];
               tap_in[3] = signed'(ram_rd_data);
            end
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == RD_LAST) begin
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            t_in       = k3;
            coef_in[0] = k2;
            coef_in[1] = k1;
            coef_in[2] = k0;
            h_cnt_in   = '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            mul_req.en  = 1'b1;
            mul_req.sel = cito_pkg::MUL_FRAC;
            state_in    = ST_ADD;
         end
         ST_ADD: begin
            t_in     = T_W'(prod_sh) + coef_ff[h_cnt_ff];
            h_cnt_in = h_cnt_ff + 2'd1;
            state_in = (h_cnt_ff == H_LAST) ? ST_SCALE : ST_MUL;
         end
         ST_SCALE: begin
            mul_req.en  = 1'b1;
            mul_req.sel = cito_pkg::MUL_AMP;
            state_in    = ST_OFFS;
         end
         ST_OFFS: begin
            u_in     = u_sum[T_W:0];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            mul_req.en  = 1'b1;
            mul_req.sel = cito_pkg::MUL_RECIP;
            state_in    = ST_SAT;
         end
         ST_SAT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = 16'(S_W'(r_sat));
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_accept) begin
         phase_in = cito_pkg::load_phase(csr_initial_phase);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         h_cnt_ff     <= '0;
         phase_ff     <= cito_pkg::load_phase('0);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         h_cnt_ff     <= h_cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      frac_ff       <= frac_in;
      amp_ff        <= amp_in;
      tap_ff        <= tap_in;
      t_ff          <= t_in;
      coef_ff       <= coef_in;
      u_ff          <= u_in;
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule

// ===== rtl/cito_chk.sv =====
// Port-level checker for the cubic interpolating wavetable oscillator.
// Bound to cubic_interp_table_oscillator_unit; depends on nothing else.
module cito_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_operation,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_sample
);

   // A sample item keeps the block busy in the next cycle.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation |=> req_stall)
      else $error("sample item did not make the block busy");

   // A table write item leaves the block free in the next cycle.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_operation |=> !req_stall)
      else $error("table write item left the block busy");

   // A new result only appears from the final step of a sample.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled result changed");

endmodule

bind cubic_interp_table_oscillator_unit cito_chk u_cito_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_sample    (rsp_sample)
);

// ===== test/tb_cubic_interp_table_oscillator_unit.sv =====
// Testbench for cubic_interp_table_oscillator_unit: loads the waveform table, drives
// directed and random items with idling on both channels, and checks every sample
// against a cycle-free predictor of the oscillator. Depends on cito_pkg and the block.
module tb_cubic_interp_table_oscillator_unit;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS = 160;
   localparam int START_PERIOD = RANDOM_ITEMS / 4;
   localparam int TAIL_ITEMS = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = 1'b0;
   logic [9:0] req_table_index = '0;
   logic signed [15:0] req_table_value = '0;
   logic signed [26:0] req_phase_increment = '0;
   logic signed [15:0] req_amplitude = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_initial_phase = '0;

   logic signed [15:0] wave_mem [cito_pkg::TABLE_SIZE];
   logic [cito_pkg::PHASE_BITS-1:0] phase_acc;
   logic signed [15:0] expected_samples [$];
   logic signed [15:0] oldest_sample;
   int failures = 0;
   int cycle_count;
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;

   cubic_interp_table_oscillator_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_table_index(req_table_index),
      .req_table_value(req_table_value),
      .req_phase_increment(req_phase_increment),
      .req_amplitude(req_amplitude),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_initial_phase(csr_initial_phase)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [cito_pkg::PHASE_BITS-1:0] reload_phase(
         input logic [15:0] start);
      logic [cito_pkg::PHASE_BITS-1:0] p;
      p = cito_pkg::PHASE_BITS'(start) << (cito_pkg::PHASE_BITS - 16);
      return p - (cito_pkg::PHASE_BITS'(1) << cito_pkg::FRAC_BITS);
   endfunction

   function automatic logic signed [15:0] predict_sample(input logic signed [15:0] amp);
      logic [9:0] i0, i1, i2, i3;
      longint a, b, c, d, k1, k2, k3, t, f, n, r;
      i0 = phase_acc[cito_pkg::PHASE_BITS-1:cito_pkg::FRAC_BITS];
      i1 = i0 + 10'd1;
      i2 = i0 + 10'd2;
      i3 = i0 + 10'd3;
      f = phase_acc[cito_pkg::FRAC_BITS-1:0];
      a = wave_mem[i0];
      b = wave_mem[i1];
      c = wave_mem[i2];
      d = wave_mem[i3];
      k3 = d - a + 3 * b - 3 * c;
      k2 = 3 * a + 3 * c - 6 * b;
      k1 = 6 * c - d - 3 * b - 2 * a;
      t = k3;
      t = ((t * f) >>> cito_pkg::FRAC_BITS) + k2;
      t = ((t * f) >>> cito_pkg::FRAC_BITS) + k1;
      t = ((t * f) >>> cito_pkg::FRAC_BITS) + 6 * b;
      n = t * longint'(amp) + 98304;
      if (n >= 0) begin
         r = n / 196608;
      end else begin
         r = -((-n + 196607) / 196608);
      end
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32768) begin
         r = -32768;
      end
      return 16'(r);
   endfunction

   task automatic issue_request(input logic op, input logic [9:0] idx,
                                input logic signed [15:0] val,
                                input logic signed [26:0] inc,
                                input logic signed [15:0] amp);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_table_index <= idx;
      req_table_value <= val;
      req_phase_increment <= inc;
      req_amplitude <= amp;
      do @(posedge clock); while (req_stall);
      if (op == OP_WRITE) begin
         wave_mem[idx] = val;
      end else begin
         expected_samples.push_back(predict_sample(amp));
         phase_acc = phase_acc + inc[cito_pkg::PHASE_BITS-1:0];
      end
   endtask

   task automatic write_word(input logic [9:0] idx, input logic signed [15:0] val);
      issue_request(OP_WRITE, idx, val, 27'($urandom), 16'($urandom));
   endtask

   task automatic take_sample(input logic signed [26:0] inc, input logic signed [15:0] amp);
      issue_request(OP_SAMPLE, 10'($urandom), 16'($urandom), inc, amp);
   endtask

   task automatic set_start_phase(input logic [15:0] start);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_initial_phase <= start;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      phase_acc = reload_phase(start);
   endtask

   task automatic random_item();
      logic signed [26:0] inc;
      logic signed [15:0] amp;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         if ($urandom_range(0, 7) == 0) begin
            write_word(10'($urandom), $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
         end else begin
            write_word(10'($urandom), 16'($urandom));
         end
         return;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: inc = 27'($urandom_range(0, 2097152)) - 27'd1048576;
         6, 7, 8: inc = 27'($urandom_range(0, 67108863));
         default: inc = 27'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: amp = 16'sh7fff;
         1: amp = 16'sh8000;
         default: amp = 16'($urandom);
      endcase
      take_sample(inc, amp);
   endtask

   task automatic test_table_load();
      phase_acc = reload_phase(16'd0);
      for (int j = 0; j < cito_pkg::TABLE_SIZE; j++) begin
         write_word(10'(j), 16'($urandom));
      end
   endtask

   task automatic test_extremes();
      set_start_phase(16'd0);
      write_word(10'd1023, 16'sh7fff);
      write_word(10'd0, 16'sh8000);
      write_word(10'd1, 16'sh7fff);
      write_word(10'd2, 16'sh8000);
      write_word(10'd3, 16'sh0000);
      take_sample(27'sd0, 16'sh7fff);
      take_sample(27'sd0, 16'sh8000);
      take_sample(27'sd0, 16'sh0000);
      take_sample(27'sd32768, 16'sh7fff);
      take_sample(27'sd67108863, 16'sh8000);
      take_sample(-27'sd67108864, 16'sh7fff);
      take_sample(27'sd1, 16'sh7fff);
      take_sample(-27'sd1, 16'sh8000);
      set_start_phase(16'hffff);
      take_sample(27'sd65536, 16'sh7fff);
      take_sample(-27'sd65536, 16'sh8000);
      set_start_phase(16'h8000);
      take_sample(27'sd12345, 16'sh4000);
   endtask

   task automatic test_random_mix();
      logic [15:0] starts [4];
      starts = '{16'($urandom), 16'hffff, 16'h0000, 16'($urandom)};
      for (int j = 0; j < RANDOM_ITEMS; j++) begin
         if (j % START_PERIOD == 0) begin
            set_start_phase(starts[j / START_PERIOD]);
         end
         random_item();
      end
   endtask

   task automatic test_steady_tail();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      for (int j = 0; j < TAIL_ITEMS; j++) begin
         random_item();
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $error("sample: expected none, actual %0d", rsp_sample);
            failures++;
         end else begin
            oldest_sample = expected_samples.pop_front();
            if (rsp_sample !== oldest_sample) begin
               $error("sample: expected %0d, actual %0d", oldest_sample, rsp_sample);
               failures++;
            end
         end
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_extremes();
      test_random_mix();
      test_steady_tail();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cito_pkg.sv
rtl/cito_ram.sv
rtl/cito_mul.sv
rtl/cubic_interp_table_oscillator_unit.sv
rtl/cito_chk.sv
test/tb_cubic_interp_table_oscillator_unit.sv
